// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Shared codes, constants and controller/datapath types of the frame bitmap
// allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	localparam int WORD_BITS   = 32;
	localparam int WORD_SEL_W  = 5;
	localparam int FRAME_SHIFT = 12;
	localparam int ADDR_W      = 32;
	localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;
	localparam int LIMIT_W     = FRAME_W + 1;
	localparam int COUNT_W     = 13;
	localparam int INDEX_W     = 12;
	localparam int STATUS_W    = 2;
	localparam int ACTION_W    = 2;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [WORD_BITS-1:0] FULL_WORD      = 32'hFFFF_FFFF;
	localparam logic [COUNT_W-1:0]   FRAME_COUNT_RST = 13'd4096;

	localparam logic [ACTION_W-1:0] ACT_MARK_USED = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_MARK_FREE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TEST      = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_ALLOC     = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

	localparam logic [PADDR_W-1:0] REG_FRAME_COUNT = 3'd0;

	typedef struct packed {
		logic clear;
		logic capture;
		logic modify;
		logic scan;
		logic emit;
	} fba_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_alloc;
		logic in_oor;
		logic in_nowords;
		logic scan_found;
		logic scan_done;
		logic res_free;
	} fba_sts_t;

endpackage

// ===== rtl/fba_if.sv =====
// ----------------------------------------------------------------------------
// fba_req_if / fba_rsp_if
// Valid/ready channels that carry request items into the allocator and
// result items out of it.
// ----------------------------------------------------------------------------
interface fba_req_if;
	import fba_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ADDR_W-1:0]   frame_address;

	modport source (output valid, output action, output frame_address, input ready);
	modport sink (input valid, input action, input frame_address, output ready);
endinterface

interface fba_rsp_if;
	import fba_pkg::*;
	logic                valid;
	logic                ready;
	logic [INDEX_W-1:0]  frame_index;
	logic                bit_was_set;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output frame_index, output bit_was_set, output status,
		input ready);
	modport sink (input valid, input frame_index, input bit_was_set, input status,
		output ready);
endinterface

// ===== rtl/fba_regs.sv =====
// ----------------------------------------------------------------------------
// fba_regs
// APB register file holding the frame_count setting.
// ----------------------------------------------------------------------------
module fba_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fba_pkg::PADDR_W-1:0]  paddr,
	input  logic [fba_pkg::PDATA_W-1:0]  pwdata,
	output logic [fba_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [fba_pkg::COUNT_W-1:0]  frame_count
);
	import fba_pkg::*;

	logic [COUNT_W-1:0] frame_count_q;
	logic               wr_hit;

	assign pready      = 1'b1;
	assign wr_hit      = psel && penable && pwrite && (paddr == REG_FRAME_COUNT);
	assign frame_count = frame_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (wr_hit) begin
			frame_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_FRAME_COUNT) begin
			prdata = PDATA_W'(frame_count_q);
		end
	end

endmodule

// ===== rtl/fba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer of the allocator: clearing sweep, request capture, single frame
// update, allocation scan and result hand-off.
// ----------------------------------------------------------------------------
module fba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fba_pkg::fba_sts_t sts,
	output fba_pkg::fba_cmd_t cmd
);
	import fba_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_MODIFY = 5'b00100,
		S_SCAN   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (sts.in_alloc) begin
						state_d = sts.in_nowords ? S_FINISH : S_SCAN;
					end else begin
						state_d = sts.in_oor ? S_FINISH : S_MODIFY;
					end
				end
			end
			S_MODIFY: begin
				cmd.modify = 1'b1;
				state_d    = S_FINISH;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_found || sts.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.res_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.res_free)
		else $error("Result emitted while the output register was still full.");

	a_scan_ends_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && (sts.scan_found || sts.scan_done)) |=> state_q == S_FINISH)
		else $error("Allocation scan did not hand over its result.");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == S_CLEAR) && state_q == S_CLEAR |-> !cmd.capture)
		else $error("Request captured during the clearing sweep.");

endmodule

// ===== rtl/fba_dp.sv =====
// ----------------------------------------------------------------------------
// fba_dp
// Datapath of the allocator: bitmap memory, request registers, scan counter,
// lowest-free-bit search and the output register.
// ----------------------------------------------------------------------------
module fba_dp #(
	parameter int MAX_FRAMES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fba_pkg::fba_cmd_t             cmd,
	output fba_pkg::fba_sts_t             sts,
	input  logic [fba_pkg::COUNT_W-1:0]   frame_count,
	input  logic [fba_pkg::ACTION_W-1:0]  req_action,
	input  logic [fba_pkg::ADDR_W-1:0]    req_frame_address,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [fba_pkg::INDEX_W-1:0]   rsp_frame_index,
	output logic                          rsp_bit_was_set,
	output logic [fba_pkg::STATUS_W-1:0]  rsp_status
);
	import fba_pkg::*;

	localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WW        = $clog2(MAP_WORDS + 1);

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 wr_en;

	logic [FRAME_W-1:0]   in_frame;
	logic [LIMIT_W-1:0]   limit;
	logic [WW-1:0]        in_words;

	logic [ACTION_W-1:0]  action_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [WW-1:0]        words_q;
	logic [WW-1:0]        scan_q;
	logic                 chk_vld_q;
	logic [AW-1:0]        chk_addr_q;

	logic [INDEX_W-1:0]   pend_idx_q;
	logic                 pend_was_q;
	logic [STATUS_W-1:0]  pend_st_q;

	logic                 rsp_valid_q;
	logic [INDEX_W-1:0]   rsp_idx_q;
	logic                 rsp_was_q;
	logic [STATUS_W-1:0]  rsp_st_q;

	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] lowest_free;
	logic [WORD_SEL_W-1:0] free_pos;
	logic                 issue;
	logic                 found;
	logic [FRAME_W-1:0]   found_frame;

	assign in_frame = req_frame_address[ADDR_W-1:FRAME_SHIFT];
	assign limit    = (LIMIT_W'(frame_count) > LIMIT_W'(MAX_FRAMES)) ?
		LIMIT_W'(MAX_FRAMES) : LIMIT_W'(frame_count);
	assign in_words = WW'(limit >> WORD_SEL_W);

	assign mask        = WORD_BITS'(1) << frame_q[WORD_SEL_W-1:0];
	assign free_bits   = ~rd_data_q;
	assign lowest_free = free_bits & (~free_bits + WORD_BITS'(1));

	always_comb begin
		free_pos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest_free[i]) begin
				free_pos = free_pos | WORD_SEL_W'(i);
			end
		end
	end

	assign found       = cmd.scan && chk_vld_q && (rd_data_q != FULL_WORD);
	assign issue       = cmd.scan && !found && (scan_q < words_q);
	assign found_frame = FRAME_W'({chk_addr_q, free_pos});

	always_comb begin
		rd_addr = in_frame[AW+WORD_SEL_W-1:WORD_SEL_W];
		if (cmd.scan) begin
			rd_addr = scan_q[AW-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = frame_q[AW+WORD_SEL_W-1:WORD_SEL_W];
		wr_data = rd_data_q | mask;
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = scan_q[AW-1:0];
			wr_data = '0;
		end else if (cmd.modify) begin
			wr_en   = (action_q == ACT_MARK_USED) || (action_q == ACT_MARK_FREE);
			wr_data = (action_q == ACT_MARK_FREE) ? (rd_data_q & ~mask) : (rd_data_q | mask);
		end else if (found) begin
			wr_en   = 1'b1;
			wr_addr = chk_addr_q;
			wr_data = rd_data_q | lowest_free;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			chk_vld_q <= 1'b0;
		end else if (cmd.capture) begin
			scan_q    <= '0;
			chk_vld_q <= 1'b0;
		end else if (cmd.clear) begin
			scan_q    <= scan_q + WW'(1);
		end else begin
			scan_q    <= scan_q + WW'(issue);
			chk_vld_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chk_addr_q <= scan_q[AW-1:0];
		end
		if (cmd.capture) begin
			action_q   <= req_action;
			frame_q    <= in_frame;
			words_q    <= in_words;
			pend_was_q <= 1'b0;
			if (req_action == ACT_ALLOC) begin
				pend_idx_q <= '0;
				pend_st_q  <= ST_NOFREE;
			end else begin
				pend_idx_q <= in_frame[INDEX_W-1:0];
				pend_st_q  <= ST_RANGE;
			end
		end else if (cmd.modify) begin
			pend_idx_q <= frame_q[INDEX_W-1:0];
			pend_was_q <= |(rd_data_q & mask);
			pend_st_q  <= ST_OK;
		end else if (found) begin
			pend_idx_q <= found_frame[INDEX_W-1:0];
			pend_was_q <= 1'b0;
			pend_st_q  <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_idx_q <= pend_idx_q;
			rsp_was_q <= pend_was_q;
			rsp_st_q  <= pend_st_q;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_frame_index = rsp_idx_q;
	assign rsp_bit_was_set = rsp_was_q;
	assign rsp_status      = rsp_st_q;

	assign sts.clr_last   = (scan_q == WW'(MAP_WORDS - 1));
	assign sts.in_alloc   = (req_action == ACT_ALLOC);
	assign sts.in_oor     = ({1'b0, in_frame} >= limit);
	assign sts.in_nowords = (in_words == '0);
	assign sts.scan_found = found;
	assign sts.scan_done  = !chk_vld_q && (scan_q >= words_q);
	assign sts.res_free   = !rsp_valid_q || rsp_ready;

	a_scan_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && chk_vld_q) |-> (WW'(chk_addr_q) < words_q))
		else $error("Allocation scan checked a word beyond the managed range.");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (WW'(wr_addr) < WW'(MAP_WORDS)))
		else $error("Bitmap write outside the memory.");

	a_nofree_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && pend_st_q == ST_NOFREE) |-> (pend_idx_q == '0 && !pend_was_q))
		else $error("Exhausted allocation reported a frame.");

	a_alloc_fresh_bit: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> ((rd_data_q & lowest_free) == '0 && $onehot(lowest_free)))
		else $error("Allocation picked a frame that was already used.");

endmodule

// ===== rtl/frame_bitmap_allocator_top.sv =====
// Mark used, mark free and test: the request passes the modify and finish states, then the output register.
// Out-of-range frame, or allocate with no whole word to scan: the modify or scan state is skipped.
// Allocate: one bitmap word read per cycle until a free frame is found or the words run out.
// One request is worked at a time; the output register holds a result while the next is taken.
// After reset a sweep clears every word of the bitmap memory;
// requests wait for it, register writes do not.
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top
// Bitmap page-frame allocator: marks, frees, tests and allocates 4 KiB frames.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top #(
	parameter int MAX_FRAMES = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	fba_req_if.sink                      req,
	fba_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fba_pkg::PADDR_W-1:0]  paddr,
	input  logic [fba_pkg::PDATA_W-1:0]  pwdata,
	output logic [fba_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import fba_pkg::*;

	fba_cmd_t           cmd;
	fba_sts_t           sts;
	logic [COUNT_W-1:0] frame_count;
	logic               req_ready;
	logic               rsp_valid;
	logic [INDEX_W-1:0] rsp_frame_index;
	logic               rsp_bit_was_set;
	logic [STATUS_W-1:0] rsp_status;

	fba_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_count (frame_count)
	);

	fba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fba_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.frame_count       (frame_count),
		.req_action        (req.action),
		.req_frame_address (req.frame_address),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp.ready),
		.rsp_frame_index   (rsp_frame_index),
		.rsp_bit_was_set   (rsp_bit_was_set),
		.rsp_status        (rsp_status)
	);

	assign req.ready       = req_ready;
	assign rsp.valid       = rsp_valid;
	assign rsp.frame_index = rsp_frame_index;
	assign rsp.bit_was_set = rsp_bit_was_set;
	assign rsp.status      = rsp_status;

endmodule

// ===== sim/frame_bitmap_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top_tb
// Self-checking bench for the frame bitmap allocator. A short table of
// requests covers the corner cases first. Randomized requests then run under
// several frame counts and handshake idle patterns. A bitmap predictor runs in
// the bench; each result item is compared in order with the typed table result, else its prediction.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top_tb;
	import fba_pkg::*;

	localparam int MAX_FRAMES      = 4096;
	localparam int MAP_WORDS       = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int DIRECTED_ROWS   = 25;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 178;

	typedef struct packed {
		logic [INDEX_W-1:0]  frame_index;
		logic                bit_was_set;
		logic [STATUS_W-1:0] status;
	} frame_result_t;

	typedef struct packed {
		logic                set_count;
		logic [COUNT_W-1:0]  count;
		logic [ACTION_W-1:0] action;
		logic [ADDR_W-1:0]   address;
		logic                typed;
		frame_result_t       result;
	} stim_row_t;

	localparam stim_row_t STEPS [DIRECTED_ROWS] = '{
		'{1'b0, 13'd0,    ACT_TEST,      32'h0000_0000, 1'b1, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_MARK_USED, 32'h0000_0FFF, 1'b1, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_TEST,      32'h0000_0000, 1'b1, '{12'd0,    1'b1, ST_OK}},
		'{1'b0, 13'd0,    ACT_ALLOC,     32'hFFFF_FFFF, 1'b1, '{12'd1,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_MARK_FREE, 32'h0000_0000, 1'b1, '{12'd0,    1'b1, ST_OK}},
		'{1'b0, 13'd0,    ACT_ALLOC,     32'h0000_0000, 1'b1, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_MARK_USED, 32'h00FF_F000, 1'b1, '{12'd4095, 1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_TEST,      32'h00FF_FFFF, 1'b1, '{12'd4095, 1'b1, ST_OK}},
		'{1'b0, 13'd0,    ACT_MARK_USED, 32'h0100_0000, 1'b1, '{12'd0,    1'b0, ST_RANGE}},
		'{1'b0, 13'd0,    ACT_TEST,      32'hFFFF_FFFF, 1'b1, '{12'hFFF,  1'b0, ST_RANGE}},
		'{1'b0, 13'd0,    ACT_MARK_FREE, 32'h0100_1000, 1'b1, '{12'd1,    1'b0, ST_RANGE}},
		'{1'b0, 13'd0,    ACT_MARK_FREE, 32'h0000_1000, 1'b1, '{12'd1,    1'b1, ST_OK}},
		'{1'b0, 13'd0,    ACT_TEST,      32'h0000_1000, 1'b1, '{12'd1,    1'b0, ST_OK}},
		'{1'b1, 13'd8191, ACT_MARK_USED, 32'h00FF_E000, 1'b0, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_TEST,      32'h0100_0000, 1'b1, '{12'd0,    1'b0, ST_RANGE}},
		'{1'b1, 13'd0,    ACT_TEST,      32'h0000_0000, 1'b1, '{12'd0,    1'b0, ST_RANGE}},
		'{1'b0, 13'd0,    ACT_ALLOC,     32'h0000_0000, 1'b1, '{12'd0,    1'b0, ST_NOFREE}},
		'{1'b1, 13'd40,   ACT_MARK_USED, 32'h0002_7000, 1'b0, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_TEST,      32'h0002_8000, 1'b1, '{12'd40,   1'b0, ST_RANGE}},
		'{1'b0, 13'd0,    ACT_ALLOC,     32'h0000_0000, 1'b0, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_MARK_FREE, 32'h0002_7000, 1'b0, '{12'd0,    1'b0, ST_OK}},
		'{1'b1, 13'd31,   ACT_MARK_USED, 32'h0001_E000, 1'b0, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_ALLOC,     32'h0000_0000, 1'b1, '{12'd0,    1'b0, ST_NOFREE}},
		'{1'b1, 13'd4096, ACT_MARK_USED, 32'h0055_5000, 1'b0, '{12'd0,    1'b0, ST_OK}},
		'{1'b0, 13'd0,    ACT_ALLOC,     32'h0000_0000, 1'b0, '{12'd0,    1'b0, ST_OK}}
	};

	localparam logic [COUNT_W-1:0] PHASE_COUNT [RANDOM_PHASES] = '{
		13'd64, 13'd4096, 13'd100, 13'd8191, 13'd33, 13'd4095, 13'd0, 13'd160
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	fba_req_if req ();
	fba_rsp_if rsp ();

	logic [WORD_BITS-1:0] frame_used [MAP_WORDS];
	logic [COUNT_W-1:0]   model_frame_count;
	frame_result_t        pending_results [$];
	int                   mismatch_count = 0;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;

	frame_bitmap_allocator_top #(
		.MAX_FRAMES(MAX_FRAMES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int unsigned frame_limit();
		return (model_frame_count > MAX_FRAMES) ? MAX_FRAMES : model_frame_count;
	endfunction

	function automatic frame_result_t apply_frame_action(input logic [ACTION_W-1:0] action,
		input logic [ADDR_W-1:0] address);
		frame_result_t       res;
		int unsigned         limit;
		int unsigned         words;
		int unsigned         w;
		int unsigned         b;
		logic [FRAME_W-1:0]  frame;
		logic                found;
		limit = frame_limit();
		res   = '0;
		found = 1'b0;
		if (action == ACT_ALLOC) begin
			res.status = ST_NOFREE;
			words = limit / WORD_BITS;
			for (w = 0; w < words && !found; w++) begin
				for (b = 0; b < WORD_BITS && !found; b++) begin
					if (!frame_used[w][b]) begin
						frame_used[w][b] = 1'b1;
						res.frame_index  = INDEX_W'(w * WORD_BITS + b);
						res.status       = ST_OK;
						found            = 1'b1;
					end
				end
			end
		end else begin
			frame = address[ADDR_W-1:FRAME_SHIFT];
			res.frame_index = frame[INDEX_W-1:0];
			if (frame >= limit) begin
				res.status = ST_RANGE;
			end else begin
				w = frame / WORD_BITS;
				b = frame % WORD_BITS;
				res.bit_was_set = frame_used[w][b];
				if (action == ACT_MARK_USED) begin
					frame_used[w][b] = 1'b1;
				end else if (action == ACT_MARK_FREE) begin
					frame_used[w][b] = 1'b0;
				end
				res.status = ST_OK;
			end
		end
		return res;
	endfunction

	function automatic logic [ACTION_W-1:0] random_action();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			return ACT_ALLOC;
		end else if (pick < 60) begin
			return ACT_MARK_FREE;
		end else if (pick < 80) begin
			return ACT_MARK_USED;
		end
		return ACT_TEST;
	endfunction

	// Most addresses land inside the managed range so that allocation meets a
	// well-populated bitmap; the rest straddle the limit or are fully random.
	function automatic logic [ADDR_W-1:0] random_address();
		int unsigned limit;
		int unsigned pick;
		int unsigned frame;
		logic [31:0] low;
		limit = frame_limit();
		pick  = $urandom_range(99);
		low   = $urandom();
		if (pick < 12) begin
			return $urandom();
		end
		if (pick < 22) begin
			frame = (limit < 2) ? $urandom_range(0, 2) : limit - 2 + $urandom_range(0, 3);
		end else if (limit > 256 && pick < 60) begin
			frame = $urandom_range(0, 255);
		end else begin
			frame = $urandom_range(0, (limit == 0) ? 3 : limit - 1);
		end
		return {frame[FRAME_W-1:0], low[FRAME_SHIFT-1:0]};
	endfunction

	task automatic send_item(input logic [ACTION_W-1:0] action, input logic [ADDR_W-1:0] address,
		input logic typed, input frame_result_t typed_result);
		frame_result_t predicted;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.action        <= action;
		req.frame_address <= address;
		do @(posedge clk); while (!req.ready);
		predicted = apply_frame_action(action, address);
		pending_results.push_back(typed ? typed_result : predicted);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_frame_count(input logic [COUNT_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_FRAME_COUNT;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		model_frame_count = value;
	endtask

	always @(posedge clk) begin
		frame_result_t want;
		frame_result_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.frame_index, rsp.bit_was_set, rsp.status};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected result item: index %0d, was_set %0b, status %0d",
						got.frame_index, got.bit_was_set, got.status);
				end
			end else begin
				want = pending_results.pop_front();
				if (got.frame_index != want.frame_index || got.bit_was_set != want.bit_was_set
					|| got.status != want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Result mismatch at %0t: index %0d/%0d, was_set %0b/%0b, %s",
							$realtime, want.frame_index, got.frame_index, want.bit_was_set,
							got.bit_was_set, $sformatf("status %0d/%0d (expected/actual)",
							want.status, got.status));
					end
				end
			end
		end
	end

	initial begin
		int row;
		int phase;
		int item;
		arst_n            <= 1'b0;
		req.valid         <= 1'b0;
		req.action        <= ACT_MARK_USED;
		req.frame_address <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= REG_FRAME_COUNT;
		pwdata            <= '0;
		model_frame_count = FRAME_COUNT_RST;
		foreach (frame_used[w]) begin
			frame_used[w] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (STEPS[row].set_count) begin
				drain_results();
				write_frame_count(STEPS[row].count);
			end
			send_item(STEPS[row].action, STEPS[row].address, STEPS[row].typed,
				STEPS[row].result);
		end

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			write_frame_count(PHASE_COUNT[phase]);
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 48;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 48;
				end
				default: begin
					send_idle_pct  = 33;
					recv_stall_pct = 33;
				end
			endcase
			for (item = 0; item < ITEMS_PER_PHASE; item++) begin
				if (item == ITEMS_PER_PHASE / 2) begin
					drain_results();
				end
				send_item(random_action(), random_address(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fba_pkg.sv
rtl/fba_if.sv
rtl/fba_regs.sv
rtl/fba_ctrl.sv
rtl/fba_dp.sv
rtl/frame_bitmap_allocator_top.sv
sim/frame_bitmap_allocator_top_tb.sv
